// ===== rtl/core/sarl_pkg.sv =====
// ----------------------------------------------------------------------------
// sarl_pkg: shared types and constants of the symbol address range lookup
// Table geometry, action and status codes, and the result record.
// ----------------------------------------------------------------------------
package sarl_pkg;

  localparam int TABLE_DEPTH   = 1024;
  localparam int IDX_W         = $clog2(TABLE_DEPTH);
  localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
  localparam int PTR_W         = CNT_W + 1;
  localparam int ADDR_W        = 32;
  localparam int MATCH_INDEX_W = 10;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_FOUND     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]        status;
    logic [IDX_W-1:0]  index;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] size;
  } sarl_res_t;

  typedef struct packed {
    logic             res_valid;
    logic [CNT_W-1:0] entry_count;
  } sarl_stat_t;

endpackage

// ===== rtl/core/sarl_ram.sv =====
// ----------------------------------------------------------------------------
// sarl_ram: generic memory with one write port and two read ports
// Read data is registered, so it appears in the cycle after the address.
// ----------------------------------------------------------------------------
module sarl_ram #(
  parameter int  DEPTH = 1024,
  parameter int  WIDTH = 32,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== rtl/core/sarl_ctrl.sv =====
// ----------------------------------------------------------------------------
// sarl_ctrl: table management and binary search sequencer
// Appends into the start table, keeps the fill count and runs the probes.
// ----------------------------------------------------------------------------
module sarl_ctrl
  import sarl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_action,
  input  logic [ADDR_W-1:0] in_addr,
  input  logic              in_exact,
  input  logic [ADDR_W-1:0] seg_end,
  input  logic              res_ready,
  output sarl_res_t         res,
  output sarl_stat_t        stat
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_RESP
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic signed [PTR_W-1:0]  low_r, low_nxt;
  logic signed [PTR_W-1:0]  high_r, high_nxt;
  logic [IDX_W-1:0]         pos_r, pos_nxt;
  logic [ADDR_W-1:0]        addr_r, addr_nxt;
  logic                     exact_r, exact_nxt;
  sarl_res_t                res_r, res_nxt;

  logic                     accept;
  logic                     wr_en;
  logic [ADDR_W-1:0]        rd_a;
  logic [ADDR_W-1:0]        rd_b;
  logic [CNT_W-1:0]         pos_plus1;
  logic [ADDR_W-1:0]        next_start;
  logic [ADDR_W-1:0]        size;
  logic [ADDR_W-1:0]        span;
  logic [ADDR_W-1:0]        limit;
  logic                     hit;
  logic                     go_low;
  logic signed [PTR_W-1:0]  pos_s;
  logic signed [PTR_W-1:0]  low_n, high_n;
  logic signed [PTR_W-1:0]  mid_sum;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign wr_en    = accept && (in_action == ACT_APPEND) && (count_r < CNT_W'(TABLE_DEPTH));

  sarl_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (ADDR_W)
  ) u_table (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (count_r[IDX_W-1:0]),
    .wdata   (in_addr),
    .raddr_a (pos_r),
    .raddr_b (pos_plus1[IDX_W-1:0]),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // Probe evaluation on the entry and its successor read last cycle.
  assign pos_plus1  = CNT_W'(pos_r) + CNT_W'(1);
  assign next_start = (pos_plus1 < count_r) ? rd_b : seg_end;
  assign size       = next_start - rd_a;
  assign span       = ((size == '0) || size[ADDR_W-1]) ? ADDR_W'(1) : size;
  assign limit      = rd_a + span;
  assign hit        = exact_r ? (rd_a == addr_r) : ((rd_a <= addr_r) && (addr_r < limit));
  assign go_low     = addr_r < rd_a;
  assign pos_s      = $signed({{(PTR_W - IDX_W){1'b0}}, pos_r});
  assign high_n     = go_low ? (pos_s - PTR_W'(1)) : high_r;
  assign low_n      = go_low ? low_r : (pos_s + PTR_W'(1));
  assign mid_sum    = low_n + high_n;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    low_nxt   = low_r;
    high_nxt  = high_r;
    pos_nxt   = pos_r;
    addr_nxt  = addr_r;
    exact_nxt = exact_r;
    res_nxt   = res_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          addr_nxt  = in_addr;
          exact_nxt = in_exact;
          res_nxt   = '{status: ST_NOT_FOUND, index: '0, start: '0, size: '0};
          state_nxt = S_RESP;
          case (in_action)
            ACT_CLEAR: begin
              count_nxt      = '0;
              res_nxt.status = ST_DONE;
            end
            ACT_APPEND: begin
              if (wr_en) begin
                count_nxt      = count_r + CNT_W'(1);
                res_nxt.status = ST_DONE;
              end else begin
                res_nxt.status = ST_FULL;
              end
            end
            ACT_LOOKUP: begin
              if (count_r != '0) begin
                low_nxt   = '0;
                high_nxt  = $signed(PTR_W'(count_r)) - PTR_W'(1);
                pos_nxt   = IDX_W'((count_r - CNT_W'(1)) >> 1);
                state_nxt = S_READ;
              end
            end
            default: begin
              res_nxt.status = ST_NOT_FOUND;
            end
          endcase
        end
      end
      S_READ: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (hit) begin
          res_nxt   = '{status: ST_FOUND, index: pos_r, start: rd_a, size: size};
          state_nxt = S_RESP;
        end else if (high_n >= low_n) begin
          low_nxt   = low_n;
          high_nxt  = high_n;
          pos_nxt   = mid_sum[IDX_W:1];
          state_nxt = S_READ;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    low_r   <= low_nxt;
    high_r  <= high_nxt;
    pos_r   <= pos_nxt;
    addr_r  <= addr_nxt;
    exact_r <= exact_nxt;
    res_r   <= res_nxt;
  end

  assign res              = res_r;
  assign stat.res_valid   = (state_r == S_RESP);
  assign stat.entry_count = count_r;

endmodule

// ===== rtl/core/symbol_address_range_lookup.sv =====
// ----------------------------------------------------------------------------
// symbol_address_range_lookup: sorted symbol table with binary search lookup
// Loads start addresses in ascending order and finds the entry that holds
// an address, either by exact start or by the range up to the next start.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake              | Contents
//  --------+-----------+------------------------+------------------------------
//  in_     | slave     | in_tvalid / in_tready  | action, exact flag, address
//  out_    | master    | out_tvalid / out_tready| status, index, start, size
//  cfg_    | write     | cfg_wr_en              | segment end address
//
// One transaction is taken at a time. A clear or an append moves the sequencer
// to its response state, and its result is loaded into the output register
// once that register is free; the sequencer then returns to idle and the next
// input can be accepted. A lookup runs at most log2 of the table depth plus
// one probes (11 for 1024 entries): every probe reads the entry and its
// successor from the registered table memory in the read state and narrows
// the bounds in the evaluation state.
// Reset clears the fill count and the handshake state; table contents are
// left as they are and only entries below the fill count are ever used.
// A stalled result waits in the output register, and the next input
// transaction is accepted as soon as the search sequencer is free.
//
module symbol_address_range_lookup
  import sarl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input transaction.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] probe_address
  input  logic [2:0]  in_tuser,   // [1:0] action, [2] exact_match
  // Result transaction.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [9:0] match_index, [41:10] match_start,
                                  // [73:42] match_size, [79:74] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  // Configuration.
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  logic [ADDR_W-1:0] seg_end_r;
  logic              out_tvalid_r;
  logic [79:0]       out_tdata_r;
  logic [1:0]        out_tuser_r;
  logic              res_ready;
  sarl_res_t         res;
  sarl_stat_t        stat;

  // The segment end address bounds the size of the last table entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_end_r <= '0;
    end else if (cfg_wr_en) begin
      seg_end_r <= cfg_wr_data;
    end
  end

  // The sequencer hands over its result once the output register is free.
  assign res_ready = !out_tvalid_r || out_tready;

  sarl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_action (in_tuser[1:0]),
    .in_addr   (in_tdata),
    .in_exact  (in_tuser[2]),
    .seg_end   (seg_end_r),
    .res_ready (res_ready),
    .res       (res),
    .stat      (stat)
  );

  // Output register: holds one finished result until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_ready) begin
      out_tvalid_r <= stat.res_valid;
    end
    if (res_ready && stat.res_valid) begin
      out_tdata_r <= {6'd0, res.size, res.start, MATCH_INDEX_W'(res.index)};
      out_tuser_r <= res.status;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef NO_ASSERTIONS
  // A result handed over by the sequencer shows up on the output next cycle.
  a_handover: assert property (@(posedge clk) disable iff (!rst_n)
    stat.res_valid && res_ready |=> out_tvalid)
    else $error("handed-over result did not reach the output register");

  // A found entry always lies inside the filled part of the table.
  a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    stat.res_valid && (res.status == ST_FOUND) |->
      ({1'b0, res.index} < stat.entry_count))
    else $error("found index beyond the fill count");

  // The fill count never passes the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.entry_count <= CNT_W'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  // No input is taken while a result waits in the sequencer.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    stat.res_valid |-> !in_tready)
    else $error("input accepted while a result is pending");
`endif

endmodule
